>>> rtl/core/befc_pkg.sv
// Shared types, constants and helpers of the binary event flag cleanup block.
// Used by befc_filter, befc_dilate and binary_event_flag_cleanup_top.
`timescale 1ns / 1ps

package befc_pkg;

  // Upper limits of the register fields after saturation.
  localparam int MAX_HALF = 8;
  localparam int MAX_RUN  = 16;
  localparam int MAX_ROLL = 16;

  // Register field widths.
  localparam int HALF_W    = 4;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 3;

  // Majority window: raw lookahead frames and cleaned history.
  localparam int WIN_W      = MAX_HALF + 1;
  localparam int HIST_W     = MAX_HALF;
  localparam int MAJ_FILL_W = $clog2(MAX_HALF + 2);
  localparam int MAJ_SUM_W  = $clog2(WIN_W + HIST_W + 1);

  // Held-frame counters of the run and gap stages.
  localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

  // Pre-roll delay line.
  localparam int DLY_W     = MAX_ROLL + 1;
  localparam int DLY_CNT_W = $clog2(DLY_W + 1);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAJ_HALF  = 3'd0,
    CFG_MIN_RUN   = 3'd1,
    CFG_MIN_GAP   = 3'd2,
    CFG_PRE_ROLL  = 3'd3,
    CFG_POST_ROLL = 3'd4
  } cfg_idx_e;

  // Saturated configuration as seen by the datapath.
  typedef struct packed {
    logic [HALF_W-1:0] half;
    logic [CNT_W-1:0]  min_run;
    logic [CNT_W-1:0]  min_gap;
    logic [CNT_W-1:0]  pre_roll;
    logic [CNT_W-1:0]  post_roll;
  } cfg_t;

  // One frame flag moving between stages, with its end-of-sequence tag.
  typedef struct packed {
    logic flag;
    logic last;
  } beat_t;

  // Saturate a count field at a limit.
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v, input int hi);
    return (int'(v) > hi) ? CNT_W'(hi) : v;
  endfunction

endpackage

>>> rtl/core/binary_event_flag_cleanup_top.sv
// Top level of the binary event flag cleanup block: configuration registers,
// input register and the filter and dilation stages. Depends on befc_pkg.
`timescale 1ns / 1ps

// Usage
// Input channel: one beat per frame, motion_flag_i with last_frame_i set on the
// final frame of a sequence. Output channel: one beat per frame, in frame order,
// keep_flag_o carries the cleaned flag and last_out_o marks the final frame's beat.
// Frames pass an input register, a majority stage, a run stage, a gap stage and
// a dilation stage, each with its own output register, and a frame that is not
// held back reaches out_valid_o through these registers in that order.
// Frames are held back while the majority lookahead (half), a short run, an
// open gap or the pre-roll lookahead is still undecided.
// Throughput is one beat per cycle while no stage holds frames or stalls. When a held run or gap is released, the
// stage sends its held frames at one per cycle and stalls its input meanwhile.
// After the final frame each stage drains its held frames the same way: up to
// half lookahead frames, 15 held ones, 15 held zeros and 16 pre-roll frames.
// A stall at out_ready_i backs up through the stage registers to in_ready_o;
// nothing is lost. Reset clears all stages and loads the register defaults
// (half 1, minimum run 2, minimum gap 2, no pre-roll, no post-roll).
// Registers are to be written through cfg_we_i only while the block is idle; the block does not enforce this.

module binary_event_flag_cleanup_top import befc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 motion_flag_i,
  input  logic                 last_frame_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 keep_flag_o,
  output logic                 last_out_o
);

  // Configuration registers.
  logic [HALF_W-1:0] maj_half_q;
  logic [CNT_W-1:0]  min_run_q, min_gap_q, pre_roll_q, post_roll_q;
  cfg_t              cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maj_half_q  <= HALF_W'(1);
      min_run_q   <= CNT_W'(2);
      min_gap_q   <= CNT_W'(2);
      pre_roll_q  <= '0;
      post_roll_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAJ_HALF:  maj_half_q  <= cfg_data_i[HALF_W-1:0];
        CFG_MIN_RUN:   min_run_q   <= cfg_data_i;
        CFG_MIN_GAP:   min_gap_q   <= cfg_data_i;
        CFG_PRE_ROLL:  pre_roll_q  <= cfg_data_i;
        CFG_POST_ROLL: post_roll_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Saturate the register fields at their limits.
  always_comb begin
    cfg.half      = (int'(maj_half_q) > MAX_HALF) ? HALF_W'(MAX_HALF) : maj_half_q;
    cfg.min_run   = clamp_cnt(min_run_q, MAX_RUN);
    cfg.min_gap   = clamp_cnt(min_gap_q, MAX_RUN);
    cfg.pre_roll  = clamp_cnt(pre_roll_q, MAX_ROLL);
    cfg.post_roll = clamp_cnt(post_roll_q, MAX_ROLL);
  end

  // Input register.
  logic  in_v_q, in_v_d;
  beat_t in_beat_q;
  logic  flt_in_ready;

  assign in_ready_o = !in_v_q || flt_in_ready;

  always_comb begin
    if (in_valid_i && in_ready_o) begin
      in_v_d = 1'b1;
    end else if (flt_in_ready) begin
      in_v_d = 1'b0;
    end else begin
      in_v_d = in_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_beat_q <= '{flag: motion_flag_i, last: last_frame_i};
  end

  // Majority, run and gap stages.
  logic  flt_valid, dil_in_ready;
  beat_t flt_beat;

  befc_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_v_q),
    .in_beat_i   (in_beat_q),
    .in_ready_o  (flt_in_ready),
    .out_valid_o (flt_valid),
    .out_beat_o  (flt_beat),
    .out_ready_i (dil_in_ready)
  );

  // Dilation stage and output register.
  beat_t out_beat;

  befc_dilate u_dilate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (flt_valid),
    .in_beat_i   (flt_beat),
    .in_ready_o  (dil_in_ready),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat),
    .out_ready_i (out_ready_i)
  );

  assign keep_flag_o = out_beat.flag;
  assign last_out_o  = out_beat.last;

endmodule

>>> rtl/core/befc_filter.sv
// Majority filter, short run removal and gap filling of the flag cleanup block.
// Depends on befc_pkg for the beat and configuration types.
`timescale 1ns / 1ps

module befc_filter import befc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  input  beat_t in_beat_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  output beat_t out_beat_o,
  input  logic  out_ready_i
);

  // ---------------------------------------------------------------------------
  // Stage 1: recursive majority
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0]      maj_win_q, maj_win_d;
  logic [MAJ_FILL_W-1:0] maj_fill_q, maj_fill_d;
  logic [HIST_W-1:0]     maj_hist_q, maj_hist_d;
  logic                  maj_flush_q, maj_flush_d;
  logic                  s1_v_q, s1_v_d;
  beat_t                 s1_beat_q;

  logic                  run_in_ready;
  logic                  s1_free, maj_take, maj_emit, maj_tag, maj_y, maj_last;
  logic [WIN_W-1:0]      maj_push, maj_w;
  logic [MAJ_FILL_W-1:0] maj_f, maj_f_rem;
  logic [MAJ_SUM_W-1:0]  maj_sum;

  assign s1_free    = !s1_v_q || run_in_ready;
  assign in_ready_o = !maj_flush_q && s1_free;
  assign maj_take   = in_valid_i && in_ready_o;

  // Window contents and emit decision for this cycle.
  always_comb begin
    maj_push = maj_win_q | (WIN_W'(in_beat_i.flag) << maj_fill_q);
    if (maj_flush_q) begin
      maj_w    = maj_win_q;
      maj_f    = maj_fill_q;
      maj_tag  = 1'b1;
      maj_emit = s1_free;
    end else begin
      maj_w    = maj_push;
      maj_f    = maj_fill_q + MAJ_FILL_W'(1);
      maj_tag  = in_beat_i.last;
      maj_emit = maj_take && (in_beat_i.last || (maj_f > MAJ_FILL_W'(cfg_i.half)));
    end
    maj_f_rem = maj_f - MAJ_FILL_W'(1);
    maj_last  = maj_tag && (maj_f_rem == '0);
  end

  // Ones count over the raw lookahead and the cleaned history.
  always_comb begin
    maj_sum = '0;
    for (int i = 0; i < WIN_W; i++) begin
      if (i <= int'(cfg_i.half)) maj_sum = maj_sum + MAJ_SUM_W'(maj_w[i]);
    end
    for (int i = 0; i < HIST_W; i++) begin
      if (i < int'(cfg_i.half)) maj_sum = maj_sum + MAJ_SUM_W'(maj_hist_q[i]);
    end
    maj_y = (maj_sum >= (MAJ_SUM_W'(cfg_i.half) + MAJ_SUM_W'(1)));
  end

  // Next state of the majority stage.
  always_comb begin
    maj_win_d   = maj_win_q;
    maj_fill_d  = maj_fill_q;
    maj_hist_d  = maj_hist_q;
    maj_flush_d = maj_flush_q;
    if (maj_emit) begin
      maj_win_d   = maj_w >> 1;
      maj_fill_d  = maj_f_rem;
      maj_hist_d  = maj_last ? '0 : ((maj_hist_q << 1) | HIST_W'(maj_y));
      maj_flush_d = maj_tag && (maj_f_rem != '0);
    end else if (maj_take) begin
      maj_win_d  = maj_push;
      maj_fill_d = maj_f;
    end
    s1_v_d = maj_emit ? 1'b1 : (run_in_ready ? 1'b0 : s1_v_q);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: short run removal
  // ---------------------------------------------------------------------------
  logic [RUN_CNT_W-1:0] run_cnt_q, run_cnt_d;
  logic                 run_conf_q, run_conf_d;
  logic                 run_rel_q, run_rel_d;
  logic                 run_rval_q, run_rval_d;
  logic                 run_tag_q, run_tag_d;
  logic                 s2_v_q, s2_v_d;
  beat_t                s2_beat_q;

  logic                 gap_in_ready;
  logic                 s2_free, run_take, run_emit, run_v, run_t, run_last;
  logic [RUN_CNT_W-1:0] run_c1, run_k, run_k_rem;

  assign s2_free      = !s2_v_q || gap_in_ready;
  assign run_in_ready = !run_rel_q && s2_free;
  assign run_take     = s1_v_q && run_in_ready;

  // Held ones are released as ones once the run is long enough, else as zeros.
  always_comb begin
    run_emit   = 1'b0;
    run_k      = run_cnt_q;
    run_v      = run_rval_q;
    run_t      = run_tag_q;
    run_cnt_d  = run_cnt_q;
    run_conf_d = run_conf_q;
    run_rel_d  = run_rel_q;
    run_rval_d = run_rval_q;
    run_tag_d  = run_tag_q;
    run_c1     = run_cnt_q + RUN_CNT_W'(1);
    if (run_rel_q) begin
      run_emit = s2_free;
    end else if (run_take) begin
      run_t = s1_beat_q.last;
      if (s1_beat_q.flag) begin
        if (run_conf_q || (run_c1 >= RUN_CNT_W'(cfg_i.min_run))) begin
          run_conf_d = 1'b1;
          run_emit   = 1'b1;
          run_k      = run_c1;
          run_v      = 1'b1;
        end else if (s1_beat_q.last) begin
          run_emit = 1'b1;
          run_k    = run_c1;
          run_v    = 1'b0;
        end else begin
          run_cnt_d = run_c1;
        end
      end else begin
        run_conf_d = 1'b0;
        run_emit   = 1'b1;
        run_k      = run_c1;
        run_v      = 1'b0;
      end
    end
    run_k_rem = run_k - RUN_CNT_W'(1);
    run_last  = run_t && (run_k_rem == '0);
    if (run_emit) begin
      run_cnt_d  = run_k_rem;
      run_rel_d  = (run_k_rem != '0);
      run_rval_d = run_v;
      run_tag_d  = run_t;
      if (run_last) run_conf_d = 1'b0;
    end
    s2_v_d = run_emit ? 1'b1 : (gap_in_ready ? 1'b0 : s2_v_q);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: gap filling
  // ---------------------------------------------------------------------------
  logic [RUN_CNT_W-1:0] gap_cnt_q, gap_cnt_d;
  logic                 gap_seen_q, gap_seen_d;
  logic                 gap_rel_q, gap_rel_d;
  logic                 gap_rval_q, gap_rval_d;
  logic                 gap_tag_q, gap_tag_d;
  logic                 s3_v_q, s3_v_d;
  beat_t                s3_beat_q;

  logic                 s3_free, gap_take, gap_emit, gap_v, gap_t, gap_last;
  logic [RUN_CNT_W-1:0] gap_c1, gap_k, gap_k_rem;

  assign s3_free      = !s3_v_q || out_ready_i;
  assign gap_in_ready = !gap_rel_q && s3_free;
  assign gap_take     = s2_v_q && gap_in_ready;

  // Held zeros become ones when a one closes the gap, else they pass as zeros.
  always_comb begin
    gap_emit   = 1'b0;
    gap_k      = gap_cnt_q;
    gap_v      = gap_rval_q;
    gap_t      = gap_tag_q;
    gap_cnt_d  = gap_cnt_q;
    gap_seen_d = gap_seen_q;
    gap_rel_d  = gap_rel_q;
    gap_rval_d = gap_rval_q;
    gap_tag_d  = gap_tag_q;
    gap_c1     = gap_cnt_q + RUN_CNT_W'(1);
    if (gap_rel_q) begin
      gap_emit = s3_free;
    end else if (gap_take) begin
      gap_t = s2_beat_q.last;
      if (s2_beat_q.flag) begin
        gap_seen_d = 1'b1;
        gap_emit   = 1'b1;
        gap_k      = gap_c1;
        gap_v      = 1'b1;
      end else if (!gap_seen_q || s2_beat_q.last ||
                   (gap_c1 >= RUN_CNT_W'(cfg_i.min_gap))) begin
        gap_seen_d = 1'b0;
        gap_emit   = 1'b1;
        gap_k      = gap_c1;
        gap_v      = 1'b0;
      end else begin
        gap_cnt_d = gap_c1;
      end
    end
    gap_k_rem = gap_k - RUN_CNT_W'(1);
    gap_last  = gap_t && (gap_k_rem == '0);
    if (gap_emit) begin
      gap_cnt_d  = gap_k_rem;
      gap_rel_d  = (gap_k_rem != '0);
      gap_rval_d = gap_v;
      gap_tag_d  = gap_t;
      if (gap_last) gap_seen_d = 1'b0;
    end
    s3_v_d = gap_emit ? 1'b1 : (out_ready_i ? 1'b0 : s3_v_q);
  end

  assign out_valid_o = s3_v_q;
  assign out_beat_o  = s3_beat_q;

  // Control state of all three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maj_win_q   <= '0;
      maj_fill_q  <= '0;
      maj_hist_q  <= '0;
      maj_flush_q <= 1'b0;
      s1_v_q      <= 1'b0;
      run_cnt_q   <= '0;
      run_conf_q  <= 1'b0;
      run_rel_q   <= 1'b0;
      run_rval_q  <= 1'b0;
      run_tag_q   <= 1'b0;
      s2_v_q      <= 1'b0;
      gap_cnt_q   <= '0;
      gap_seen_q  <= 1'b0;
      gap_rel_q   <= 1'b0;
      gap_rval_q  <= 1'b0;
      gap_tag_q   <= 1'b0;
      s3_v_q      <= 1'b0;
    end else begin
      maj_win_q   <= maj_win_d;
      maj_fill_q  <= maj_fill_d;
      maj_hist_q  <= maj_hist_d;
      maj_flush_q <= maj_flush_d;
      s1_v_q      <= s1_v_d;
      run_cnt_q   <= run_cnt_d;
      run_conf_q  <= run_conf_d;
      run_rel_q   <= run_rel_d;
      run_rval_q  <= run_rval_d;
      run_tag_q   <= run_tag_d;
      s2_v_q      <= s2_v_d;
      gap_cnt_q   <= gap_cnt_d;
      gap_seen_q  <= gap_seen_d;
      gap_rel_q   <= gap_rel_d;
      gap_rval_q  <= gap_rval_d;
      gap_tag_q   <= gap_tag_d;
      s3_v_q      <= s3_v_d;
    end
  end

  // Stage output beats.
  always_ff @(posedge clk_i) begin
    if (maj_emit) s1_beat_q <= '{flag: maj_y, last: maj_last};
    if (run_emit) s2_beat_q <= '{flag: run_v, last: run_last};
    if (gap_emit) s3_beat_q <= '{flag: gap_v, last: gap_last};
  end

  // A confirmed run holds no frames once its release is done.
  a_run_conf_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_conf_q && !run_rel_q) |-> (run_cnt_q == '0))
    else $error("run stage holds frames while the run is confirmed");

  // Zeros are only held after a one has been seen.
  a_gap_hold_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((gap_cnt_q != '0) && !gap_rel_q) |-> gap_seen_q)
    else $error("gap stage holds zeros without a leading one");

  // The majority window never holds more frames than its lookahead.
  a_maj_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(maj_fill_q) <= MAX_HALF)
    else $error("majority window overfilled");

endmodule

>>> rtl/core/befc_dilate.sv
// Pre-roll and post-roll dilation stage of the flag cleanup block, with the
// output register. Depends on befc_pkg for the beat and configuration types.
`timescale 1ns / 1ps

module befc_dilate import befc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  input  beat_t in_beat_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  output beat_t out_beat_o,
  input  logic  out_ready_i
);

  logic [DLY_W-1:0]     dly_q, dly_d;
  logic [DLY_CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]     post_q, post_d;
  logic                 flush_q, flush_d;
  logic                 ov_q, ov_d;
  beat_t                obeat_q;

  logic                 free, take, emit, tag, keep, last;
  logic [DLY_W-1:0]     push, dwin;
  logic [DLY_CNT_W-1:0] f_cur, f_rem;
  logic [CNT_W-1:0]     post_n;

  assign free       = !ov_q || out_ready_i;
  assign in_ready_o = !flush_q && free;
  assign take       = in_valid_i && in_ready_o;

  // Delay line contents and pop decision.
  always_comb begin
    push = dly_q | (DLY_W'(in_beat_i.flag) << fill_q);
    if (flush_q) begin
      dwin  = dly_q;
      f_cur = fill_q;
      tag   = 1'b1;
      emit  = free;
    end else begin
      dwin  = push;
      f_cur = fill_q + DLY_CNT_W'(1);
      tag   = in_beat_i.last;
      emit  = take && (in_beat_i.last || (f_cur > DLY_CNT_W'(cfg_i.pre_roll)));
    end
    f_rem = f_cur - DLY_CNT_W'(1);
    last  = tag && (f_rem == '0);
  end

  // The popped frame is kept if it or any frame in its lookahead is set, or
  // while the post-roll of an earlier run is still running.
  always_comb begin
    keep = (|dwin) || (post_q != '0);
    if (dwin[0]) begin
      post_n = cfg_i.post_roll;
    end else if (post_q != '0) begin
      post_n = post_q - CNT_W'(1);
    end else begin
      post_n = post_q;
    end
  end

  // Next state.
  always_comb begin
    dly_d   = dly_q;
    fill_d  = fill_q;
    post_d  = post_q;
    flush_d = flush_q;
    if (emit) begin
      dly_d   = dwin >> 1;
      fill_d  = f_rem;
      post_d  = last ? '0 : post_n;
      flush_d = tag && (f_rem != '0);
    end else if (take) begin
      dly_d  = push;
      fill_d = f_cur;
    end
    ov_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q   <= '0;
      fill_q  <= '0;
      post_q  <= '0;
      flush_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      dly_q   <= dly_d;
      fill_q  <= fill_d;
      post_q  <= post_d;
      flush_q <= flush_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) obeat_q <= '{flag: keep, last: last};
  end

  assign out_valid_o = ov_q;
  assign out_beat_o  = obeat_q;

  // After the final frame of a sequence the delay line, fill count, post-roll and flush state are back at reset.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> ((fill_q == '0) && (post_q == '0) && !flush_q && (dly_q == '0)))
    else $error("dilation state not cleared after the final frame");

  // The delay line never holds more than the largest pre-roll.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= MAX_ROLL)
    else $error("pre-roll delay line overfilled");

  // A waiting output beat keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(obeat_q)))
    else $error("output beat changed while waiting");

endmodule
